/* rtl/dwq_pkg.sv */
`default_nettype none

package dwq_pkg;

    // Command codes carried on the input tuser field.
    localparam logic [1:0] CMD_ENQUEUE = 2'd0;
    localparam logic [1:0] CMD_PROMOTE = 2'd1;
    localparam logic [1:0] CMD_POP     = 2'd2;
    localparam logic [1:0] CMD_PEEK    = 2'd3;

    // Result status codes.
    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;

    // Fixed field widths of the stream payload.
    localparam int CHUNK_W  = 6;
    localparam int SECT_W   = 3;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 8;

    // One queued (chunk slot, section) pair.
    typedef struct packed {
        logic [SECT_W-1:0]  section;
        logic [CHUNK_W-1:0] chunk;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                clr_step;
        logic                load_in;
        logic                bm_rd_pair;
        logic                bm_rd_qdata;
        logic                bm_set;
        logic                bm_clr;
        logic                q_rd_first;
        logic                q_rd_next;
        logic                q_wr_tail;
        logic                q_wr_carry;
        logic                q_wr_shift;
        logic                carry_load;
        logic                head_load;
        logic                count_inc;
        logic                count_dec;
        logic                res_load;
        logic                res_head;
        logic [STATUS_W-1:0] res_status;
    } dwq_cmd_t;

    // Status from the datapath back to the controller.
    typedef struct packed {
        logic       clr_last;
        logic [1:0] op;
        logic       in_range;
        logic       queued;
        logic       full;
        logic       empty;
        logic       match;
        logic       last_pos;
        logic       more;
        logic       out_free;
    } dwq_stat_t;

endpackage

`default_nettype wire

/* rtl/dwq_datapath.sv */
`default_nettype none

module dwq_datapath #(
    parameter int QUEUE_DEPTH = 128,
    parameter int CHUNK_SLOTS = 64,
    parameter int SECTIONS    = 8
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire dwq_pkg::dwq_cmd_t  cmd,
    output dwq_pkg::dwq_stat_t      stat,
    input  wire  [15:0]             s_tdata,   // chunk_index[5:0], section_index[8:6]
    input  wire  [1:0]              s_tuser,   // cmd[1:0]
    output logic                    m_tvalid,
    input  wire                     m_tready,
    output logic [23:0]             m_tdata    // status, entry_chunk, entry_section, depth
);
    import dwq_pkg::*;

    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);
    localparam int CW = (CHUNK_SLOTS > 1) ? $clog2(CHUNK_SLOTS) : 1;
    localparam int SW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam logic [SECTIONS-1:0] BIT0 = SECTIONS'(1);

    // Row of the bitmap that holds a chunk slot.
    function automatic logic [CW-1:0] row_of(input logic [CHUNK_W-1:0] c);
        logic [15:0] ext;
        ext = {{(16 - CHUNK_W){1'b0}}, c};
        return ext[CW-1:0];
    endfunction

    // Bit within a bitmap row that belongs to a section.
    function automatic logic [SW-1:0] sel_of(input logic [SECT_W-1:0] s);
        logic [15:0] ext;
        ext = {{(16 - SECT_W){1'b0}}, s};
        return ext[SW-1:0];
    endfunction

    // Storage.
    entry_t              q_mem [QUEUE_DEPTH];
    logic [SECTIONS-1:0] bm_mem [CHUNK_SLOTS];

    entry_t              q_rdata_reg;
    logic [SECTIONS-1:0] bm_rdata_reg;

    logic [1:0]          op_reg;
    entry_t              pair_reg;
    entry_t              carry_reg;
    entry_t              head_reg;
    logic [NW-1:0]       count_reg;
    logic [NW-1:0]       idx_reg;
    logic [CW-1:0]       clr_row_reg;

    logic                m_tvalid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    entry_t              out_entry_reg;
    logic [DEPTH_W-1:0]  out_depth_reg;

    logic [NW-1:0]       idx_p1;
    logic [NW-1:0]       idx_m1;
    logic [15:0]         chunk_ext;
    logic [15:0]         sect_ext;
    logic [15:0]         count_ext;
    entry_t              in_pair;

    logic                q_re;
    logic [QW-1:0]       q_raddr;
    logic                q_we;
    logic [QW-1:0]       q_waddr;
    entry_t              q_wdata;

    logic                bm_re;
    logic [CW-1:0]       bm_raddr;
    logic                bm_we;
    logic [CW-1:0]       bm_waddr;
    logic [SECTIONS-1:0] bm_wdata;

    assign in_pair.chunk   = s_tdata[CHUNK_W-1:0];
    assign in_pair.section = s_tdata[CHUNK_W+SECT_W-1:CHUNK_W];

    assign idx_p1    = idx_reg + NW'(1);
    assign idx_m1    = idx_reg - NW'(1);
    assign chunk_ext = {{(16 - CHUNK_W){1'b0}}, pair_reg.chunk};
    assign sect_ext  = {{(16 - SECT_W){1'b0}}, pair_reg.section};
    assign count_ext = 16'(count_reg);

    // Queue memory port selection.
    assign q_re    = cmd.q_rd_first | cmd.q_rd_next;
    assign q_raddr = cmd.q_rd_first ? QW'(0) : idx_p1[QW-1:0];
    assign q_we    = cmd.q_wr_tail | cmd.q_wr_carry | cmd.q_wr_shift;

    always_comb begin
        q_waddr = idx_reg[QW-1:0];
        q_wdata = carry_reg;
        if (cmd.q_wr_tail) begin
            q_waddr = count_reg[QW-1:0];
            q_wdata = pair_reg;
        end else if (cmd.q_wr_shift) begin
            q_waddr = idx_m1[QW-1:0];
            q_wdata = q_rdata_reg;
        end
    end

    // Bitmap memory port selection.
    assign bm_re    = cmd.bm_rd_pair | cmd.bm_rd_qdata;
    assign bm_raddr = cmd.bm_rd_qdata ? row_of(q_rdata_reg.chunk) : row_of(pair_reg.chunk);
    assign bm_we    = cmd.clr_step | cmd.bm_set | cmd.bm_clr;

    always_comb begin
        bm_waddr = clr_row_reg;
        bm_wdata = '0;
        if (cmd.bm_set) begin
            bm_waddr = row_of(pair_reg.chunk);
            bm_wdata = bm_rdata_reg | (BIT0 << sel_of(pair_reg.section));
        end else if (cmd.bm_clr) begin
            bm_waddr = row_of(head_reg.chunk);
            bm_wdata = bm_rdata_reg & ~(BIT0 << sel_of(head_reg.section));
        end
    end

    // Memories with registered read data.
    always_ff @(posedge aclk) begin
        if (q_we) begin
            q_mem[q_waddr] <= q_wdata;
        end
        if (q_re) begin
            q_rdata_reg <= q_mem[q_raddr];
        end
        if (bm_we) begin
            bm_mem[bm_waddr] <= bm_wdata;
        end
        if (bm_re) begin
            bm_rdata_reg <= bm_mem[bm_raddr];
        end
    end

    // Command capture, walk pointer and carried entries.
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg   <= s_tuser;
            pair_reg <= in_pair;
        end
        if (cmd.q_rd_first) begin
            idx_reg <= '0;
        end else if (cmd.q_rd_next) begin
            idx_reg <= idx_p1;
        end
        if (cmd.carry_load) begin
            carry_reg <= pair_reg;
        end else if (cmd.q_wr_carry) begin
            carry_reg <= q_rdata_reg;
        end
        if (cmd.head_load) begin
            head_reg <= q_rdata_reg;
        end
    end

    // Fill count and clearing sweep.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            clr_row_reg <= '0;
        end else begin
            if (cmd.count_inc) begin
                count_reg <= count_reg + NW'(1);
            end else if (cmd.count_dec) begin
                count_reg <= count_reg - NW'(1);
            end
            if (cmd.clr_step) begin
                clr_row_reg <= clr_row_reg + CW'(1);
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.res_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            out_status_reg <= cmd.res_status;
            out_entry_reg  <= cmd.res_head ? head_reg : '0;
            out_depth_reg  <= count_ext[DEPTH_W-1:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0000, out_depth_reg, out_entry_reg.section, out_entry_reg.chunk,
                       out_status_reg};

    // Status back to the controller.
    always_comb begin
        stat.clr_last = (clr_row_reg == CW'(CHUNK_SLOTS - 1));
        stat.op       = op_reg;
        stat.in_range = (chunk_ext < 16'(CHUNK_SLOTS)) && (sect_ext < 16'(SECTIONS));
        stat.queued   = bm_rdata_reg[sel_of(pair_reg.section)];
        stat.full     = (count_reg >= NW'(QUEUE_DEPTH));
        stat.empty    = (count_reg == '0);
        stat.match    = (q_rdata_reg == pair_reg);
        stat.last_pos = (idx_p1 == count_reg);
        stat.more     = (idx_reg < count_reg);
        stat.out_free = !m_tvalid_reg || m_tready;
    end

endmodule

`default_nettype wire

/* rtl/dwq_ctrl.sv */
`default_nettype none

module dwq_ctrl (
    input  wire                     aclk,
    input  wire                     aresetn,
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire dwq_pkg::dwq_stat_t stat,
    output dwq_pkg::dwq_cmd_t       cmd
);
    import dwq_pkg::*;

    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_BM_RD     = 4'd2;
    localparam logic [3:0] S_BM_CHK    = 4'd3;
    localparam logic [3:0] S_PRO_START = 4'd4;
    localparam logic [3:0] S_PRO_RUN   = 4'd5;
    localparam logic [3:0] S_POP_START = 4'd6;
    localparam logic [3:0] S_POP_HEAD  = 4'd7;
    localparam logic [3:0] S_POP_BMCLR = 4'd8;
    localparam logic [3:0] S_POP_SHIFT = 4'd9;
    localparam logic [3:0] S_RESULT    = 4'd10;

    logic [3:0]          state_reg;
    logic [3:0]          state_next;
    logic [STATUS_W-1:0] res_status_reg;
    logic [STATUS_W-1:0] res_status_next;
    logic                res_head_reg;
    logic                res_head_next;

    // Next state and datapath commands.
    always_comb begin
        cmd             = '0;
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_head_next   = res_head_reg;
        s_tready        = 1'b0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load_in   = 1'b1;
                    res_head_next = 1'b0;
                    state_next    = S_BM_RD;
                end
            end
            S_BM_RD: begin
                // Bitmap row read for edits; pops and peeks branch off here.
                cmd.bm_rd_pair = 1'b1;
                if (stat.op == CMD_ENQUEUE || stat.op == CMD_PROMOTE) begin
                    state_next = S_BM_CHK;
                end else begin
                    state_next = S_POP_START;
                end
            end
            S_BM_CHK: begin
                state_next = S_RESULT;
                if (!stat.in_range) begin
                    res_status_next = ST_NOTFOUND;
                end else if (stat.op == CMD_ENQUEUE) begin
                    if (stat.queued) begin
                        res_status_next = ST_DUP;
                    end else if (stat.full) begin
                        res_status_next = ST_FULL;
                    end else begin
                        cmd.bm_set      = 1'b1;
                        cmd.q_wr_tail   = 1'b1;
                        cmd.count_inc   = 1'b1;
                        res_status_next = ST_DONE;
                    end
                end else if (!stat.queued) begin
                    res_status_next = ST_NOTFOUND;
                end else begin
                    state_next = S_PRO_START;
                end
            end
            S_PRO_START: begin
                cmd.q_rd_first = 1'b1;
                cmd.carry_load = 1'b1;
                state_next     = S_PRO_RUN;
            end
            S_PRO_RUN: begin
                // Rotate entries back by one until the promoted pair is reached.
                cmd.q_wr_carry = 1'b1;
                cmd.q_rd_next  = 1'b1;
                if (stat.match) begin
                    res_status_next = ST_DONE;
                    state_next      = S_RESULT;
                end else if (stat.last_pos) begin
                    res_status_next = ST_NOTFOUND;
                    state_next      = S_RESULT;
                end
            end
            S_POP_START: begin
                if (stat.empty) begin
                    res_status_next = ST_EMPTY;
                    state_next      = S_RESULT;
                end else begin
                    cmd.q_rd_first = 1'b1;
                    state_next     = S_POP_HEAD;
                end
            end
            S_POP_HEAD: begin
                cmd.head_load   = 1'b1;
                cmd.bm_rd_qdata = 1'b1;
                if (stat.op == CMD_PEEK) begin
                    res_status_next = ST_DONE;
                    res_head_next   = 1'b1;
                    state_next      = S_RESULT;
                end else begin
                    cmd.q_rd_next = 1'b1;
                    state_next    = S_POP_BMCLR;
                end
            end
            S_POP_BMCLR: begin
                cmd.bm_clr = 1'b1;
                state_next = S_POP_SHIFT;
            end
            S_POP_SHIFT: begin
                // Move each remaining entry forward by one place.
                if (stat.more) begin
                    cmd.q_wr_shift = 1'b1;
                    cmd.q_rd_next  = 1'b1;
                end else begin
                    cmd.count_dec   = 1'b1;
                    res_status_next = ST_DONE;
                    res_head_next   = 1'b1;
                    state_next      = S_RESULT;
                end
            end
            S_RESULT: begin
                if (stat.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        cmd.res_status = res_status_reg;
        cmd.res_head   = res_head_reg;
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            res_status_reg <= ST_DONE;
            res_head_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            res_status_reg <= res_status_next;
            res_head_reg   <= res_head_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/dedup_work_queue_move_to_front.sv */
// Deduplicating work queue with move-to-front; one beat in, one beat out per command.
// Enqueue and commands rejected at the bitmap check or on an empty queue take the shortest path;
// peek adds a head read, promote grows with the position of the pair, pop with the depth before it.
// The shift walks one queue entry per cycle; the next beat is taken the cycle after the result
// is registered, and an output stall holds the command in the result state.
// After reset the bitmap is cleared one row per cycle over all CHUNK_SLOTS rows with s_tready low.
`default_nettype none

module dedup_work_queue_move_to_front #(
    parameter int QUEUE_DEPTH = 128,
    parameter int CHUNK_SLOTS = 64,
    parameter int SECTIONS    = 8
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // chunk_index[5:0], section_index[8:6], zero pad
    input  wire  [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata    // status[2:0], entry_chunk[8:3], entry_section[11:9],
                                   // depth[19:12], zero pad
);
    import dwq_pkg::*;

    dwq_cmd_t  cmd;
    dwq_stat_t stat;

    dwq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dwq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CHUNK_SLOTS (CHUNK_SLOTS),
        .SECTIONS    (SECTIONS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

`default_nettype wire
